FILE: hw/rtl/bgr_pkg.sv
// Shared types, constants and helpers of the bitmap glyph rasterizer.
package bgr_pkg;

	localparam int MAX_GLYPHS_DEF = 256;
	localparam int MAX_HEIGHT_DEF = 32;
	localparam int MAX_WIDTH_DEF  = 16;
	localparam int ADDR_BITS_DEF  = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd3;

	localparam logic [4:0]  GLYPH_WIDTH_RST  = 5'd8;
	localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;
	localparam logic [8:0]  GLYPH_COUNT_RST  = 9'd256;
	localparam logic [12:0] SCREEN_WIDTH_RST = 13'd800;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DRAW = 1'b1
	} op_t;

	typedef struct packed {
		logic [4:0]  glyph_width;
		logic [5:0]  glyph_height;
		logic [8:0]  glyph_count;
		logic [12:0] screen_width;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  code;
		logic [4:0]  row;
		logic [15:0] bits;
		logic [11:0] px;
		logic [11:0] py;
		logic [23:0] color;
	} cmd_t;

	function automatic logic [5:0] sat_height(input logic [5:0] h, input int max_h);
		if (int'(h) > max_h) begin
			return 6'(max_h);
		end
		return h;
	endfunction

	function automatic logic [15:0] width_mask(input logic [4:0] w, input int max_w);
		logic [4:0]  ws;
		logic [16:0] m;
		ws = (int'(w) > max_w) ? 5'(max_w) : w;
		m  = (17'd1 << ws) - 17'd1;
		return m[15:0];
	endfunction

endpackage

FILE: hw/rtl/bitmap_glyph_rasterizer.sv
// Top level of the bitmap glyph rasterizer: configuration registers and block wiring.
//
// A load item writes one glyph row into the on-chip glyph store as the row sequencer
// takes it from the queue; a draw item passes there through a step that takes the
// command, a step for the pos_y * screen_width multiply, then one row per cycle, unless
// the output stalls, through the single read port of the glyph store. A four-entry
// command queue sits between the input and the sequencer, and the output register plus
// one read stage hold rows while the output stalls. The glyph store is not cleared at
// reset; rows must be loaded before they are drawn. Configuration is to be written
// through cfg_valid/cfg_ready while the block is idle; the block does not enforce this.
module bitmap_glyph_rasterizer #(
	parameter int MAX_GLYPHS = bgr_pkg::MAX_GLYPHS_DEF,
	parameter int MAX_HEIGHT = bgr_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH  = bgr_pkg::MAX_WIDTH_DEF,
	parameter int ADDR_BITS  = bgr_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [7:0]                    char_code,
	input  logic [4:0]                    glyph_row,
	input  logic [15:0]                   row_bits,
	input  logic [11:0]                   pos_x,
	input  logic [11:0]                   pos_y,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [23:0]                   row_address,
	output logic [15:0]                   pixel_mask,
	output logic [23:0]                   pixel_color,
	output logic                          last_row
);

	bgr_pkg::cfg_t cfg_q;
	bgr_pkg::cmd_t push_cmd;
	bgr_pkg::cmd_t head_cmd;
	logic          push;
	logic          pop;
	logic          empty;
	logic          full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width  <= bgr_pkg::GLYPH_WIDTH_RST;
			cfg_q.glyph_height <= bgr_pkg::GLYPH_HEIGHT_RST;
			cfg_q.glyph_count  <= bgr_pkg::GLYPH_COUNT_RST;
			cfg_q.screen_width <= bgr_pkg::SCREEN_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bgr_pkg::REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= cfg_data[4:0];
				bgr_pkg::REG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data[5:0];
				bgr_pkg::REG_GLYPH_COUNT:  cfg_q.glyph_count  <= cfg_data[8:0];
				bgr_pkg::REG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	bgr_front #(
		.MAX_GLYPHS(MAX_GLYPHS),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.char_code (char_code),
		.glyph_row (glyph_row),
		.row_bits  (row_bits),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cfg       (cfg_q),
		.full      (full),
		.push      (push),
		.cmd       (push_cmd)
	);

	bgr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.rdata  (head_cmd),
		.empty  (empty),
		.full   (full)
	);

	bgr_back #(
		.MAX_GLYPHS(MAX_GLYPHS),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_WIDTH (MAX_WIDTH),
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head_cmd),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row_address (row_address),
		.pixel_mask  (pixel_mask),
		.pixel_color (pixel_color),
		.last_row    (last_row)
	);

endmodule

FILE: hw/rtl/bgr_front.sv
// Front end: accepts items, drops ignored ones and resolves the glyph to draw.
module bgr_front #(
	parameter int MAX_GLYPHS = bgr_pkg::MAX_GLYPHS_DEF,
	parameter int MAX_HEIGHT = bgr_pkg::MAX_HEIGHT_DEF
) (
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          op,
	input  logic [7:0]    char_code,
	input  logic [4:0]    glyph_row,
	input  logic [15:0]   row_bits,
	input  logic [11:0]   pos_x,
	input  logic [11:0]   pos_y,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	input  bgr_pkg::cfg_t cfg,
	input  logic          full,
	output logic          push,
	output bgr_pkg::cmd_t cmd
);

	logic code_ok;
	logic row_ok;
	logic keep;
	logic [7:0] draw_glyph;
	bgr_pkg::op_t op_in;

	assign op_in   = bgr_pkg::op_t'(op);
	assign code_ok = {1'b0, char_code} < 9'(MAX_GLYPHS);
	assign row_ok  = {1'b0, glyph_row} < 6'(MAX_HEIGHT);

	// fall back to glyph 0 for code 0 and codes past the font
	assign draw_glyph = (char_code != 8'd0 && {1'b0, char_code} < cfg.glyph_count && code_ok)
		? char_code : 8'd0;

	always_comb begin
		unique case (op_in)
			bgr_pkg::OP_LOAD: keep = code_ok && row_ok;
			bgr_pkg::OP_DRAW: keep = cfg.glyph_height != 6'd0;
			default:          keep = 1'b0;
		endcase
	end

	assign in_stall = full;
	assign push     = in_valid && !full && keep;

	always_comb begin
		cmd.op    = op_in;
		cmd.code  = (op_in == bgr_pkg::OP_DRAW) ? draw_glyph : char_code;
		cmd.row   = glyph_row;
		cmd.bits  = row_bits;
		cmd.px    = pos_x;
		cmd.py    = pos_y;
		cmd.color = {red, green, blue};
	end

endmodule

FILE: hw/rtl/bgr_queue.sv
// Short command queue between the front end and the row sequencer.
module bgr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bgr_pkg::cmd_t wdata,
	input  logic          pop,
	output bgr_pkg::cmd_t rdata,
	output logic          empty,
	output logic          full
);

	bgr_pkg::cmd_t entry_q [bgr_pkg::QUEUE_DEPTH];
	logic [bgr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [bgr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [bgr_pkg::QPTR_W:0]   count_q;

	assign empty = count_q == '0;
	assign full  = count_q == (bgr_pkg::QPTR_W + 1)'(bgr_pkg::QUEUE_DEPTH);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a beat");

endmodule

FILE: hw/rtl/bgr_back.sv
// Back end: glyph row store, row sequencer, address generator and output stages.
module bgr_back #(
	parameter int MAX_GLYPHS = bgr_pkg::MAX_GLYPHS_DEF,
	parameter int MAX_HEIGHT = bgr_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH  = bgr_pkg::MAX_WIDTH_DEF,
	parameter int ADDR_BITS  = bgr_pkg::ADDR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bgr_pkg::cfg_t cfg,
	input  bgr_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [23:0]   row_address,
	output logic [15:0]   pixel_mask,
	output logic [23:0]   pixel_color,
	output logic          last_row
);

	localparam int DEPTH = MAX_GLYPHS * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GW    = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_ROWS  = 3'b100
	} state_t;

	logic [15:0] glyph_store [DEPTH];

	state_t          state_q;
	logic [GW-1:0]   glyph_q;
	logic [11:0]     px_q;
	logic [11:0]     py_q;
	logic [23:0]     color_q;
	logic [RW-1:0]   row_q;
	logic [ADDR_BITS-1:0] acc_q;

	logic                 valid_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [23:0]          color_s1;
	logic                 last_s1;
	logic [15:0]          rdata_s1;

	logic [5:0]    hm1;
	logic [15:0]   wmask;
	logic          last;
	logic          adv;
	logic          issue;
	logic          load_now;
	logic          draw_now;
	logic [AW-1:0] wr_idx;
	logic [AW-1:0] rd_idx;
	logic [25:0]   base;

	assign hm1   = bgr_pkg::sat_height(cfg.glyph_height, MAX_HEIGHT) - 6'd1;
	assign wmask = bgr_pkg::width_mask(cfg.glyph_width, MAX_WIDTH);
	assign last  = 6'(row_q) == hm1;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign load_now = pop && head.op == bgr_pkg::OP_LOAD;
	assign draw_now = pop && head.op == bgr_pkg::OP_DRAW;

	assign adv   = valid_s1 && (!out_valid || !out_stall);
	assign issue = (state_q == ST_ROWS) && (!valid_s1 || adv);

	assign wr_idx = AW'(head.code[GW-1:0]) * AW'(MAX_HEIGHT) + AW'(head.row[RW-1:0]);
	assign rd_idx = AW'(glyph_q) * AW'(MAX_HEIGHT) + AW'(row_q);
	assign base   = 26'(py_q) * 26'(cfg.screen_width) + 26'(px_q);

	always_ff @(posedge clk) begin
		if (load_now) begin
			glyph_store[wr_idx] <= head.bits;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= glyph_store[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (draw_now) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (issue && last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (draw_now) begin
			glyph_q <= head.code[GW-1:0];
			px_q    <= head.px;
			py_q    <= head.py;
			color_q <= head.color;
		end
		if (state_q == ST_SETUP) begin
			acc_q <= ADDR_BITS'(base);
			row_q <= '0;
		end else if (issue) begin
			acc_q <= acc_q + ADDR_BITS'(cfg.screen_width);
			row_q <= row_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1  <= acc_q;
			color_s1 <= color_q;
			last_s1  <= last;
		end
		if (adv) begin
			row_address <= 24'(addr_s1);
			pixel_mask  <= rdata_s1 & wmask;
			pixel_color <= color_s1;
			last_row    <= last_s1;
		end
	end

	a_last_ends_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last) |=> state_q == ST_IDLE)
		else $error("sequencer kept running past the last row");

	a_setup_starts_rows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP |=> state_q == ST_ROWS && row_q == '0)
		else $error("row sequence did not start at row zero");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1 && $stable(addr_s1) && $stable(last_s1))
		else $error("read stage changed while blocked");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("row lost between read stage and output");

endmodule
